// ===== hdl/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types, codes and helper functions of the typed frame receiver.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int NumTypes = 6;
  localparam int NumMarks = 5;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;
  localparam int LenW     = 8;

  typedef logic [2:0]          frame_type_t;
  typedef logic [NumMarks-1:0] marks_t;
  typedef logic [NumTypes-1:0][LenW-1:0] len_table_t;

  localparam frame_type_t TYPE_DD = 3'd0;
  localparam frame_type_t TYPE_D2 = 3'd1;
  localparam frame_type_t TYPE_D4 = 3'd2;
  localparam frame_type_t TYPE_C1 = 3'd3;
  localparam frame_type_t TYPE_CC = 3'd4;
  localparam frame_type_t TYPE_CD = 3'd5;

  localparam logic [7:0] START_DD = 8'hDD;
  localparam logic [7:0] START_D2 = 8'hD2;
  localparam logic [7:0] START_D4 = 8'hD4;
  localparam logic [7:0] START_C1 = 8'hC1;
  localparam logic [7:0] START_CC = 8'hCC;
  localparam logic [7:0] START_CD = 8'hCD;

  localparam logic [7:0] CK_OFFSET = 8'd170;
  localparam logic [7:0] CNT_MAX   = 8'hFF;
  localparam logic [7:0] LEN_RESET = 8'd2;

  localparam marks_t ALL_MARKS = 5'h1F;
  localparam marks_t CC_MARK   = 5'h10;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_LEN_DD = 3'd0;
  localparam logic [2:0] REG_LEN_D2 = 3'd1;
  localparam logic [2:0] REG_LEN_D4 = 3'd2;
  localparam logic [2:0] REG_LEN_C1 = 3'd3;
  localparam logic [2:0] REG_LEN_CC = 3'd4;
  localparam logic [2:0] REG_LEN_CD = 3'd5;

  typedef struct packed {
    logic        hit;
    frame_type_t ftype;
  } start_match_t;

  function automatic start_match_t match_start(input logic [7:0] b);
    start_match_t m;
    m.hit   = 1'b1;
    m.ftype = TYPE_DD;
    unique case (b)
      START_DD: m.ftype = TYPE_DD;
      START_D2: m.ftype = TYPE_D2;
      START_D4: m.ftype = TYPE_D4;
      START_C1: m.ftype = TYPE_C1;
      START_CC: m.ftype = TYPE_CC;
      START_CD: m.ftype = TYPE_CD;
      default:  m.hit   = 1'b0;
    endcase
    return m;
  endfunction

  // CD frames own no mark.
  function automatic marks_t type_mark(input frame_type_t t);
    marks_t m;
    m = '0;
    unique case (t)
      TYPE_DD: m = 5'b00001;
      TYPE_D2: m = 5'b00010;
      TYPE_D4: m = 5'b00100;
      TYPE_C1: m = 5'b01000;
      TYPE_CC: m = 5'b10000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/tfr_if.sv =====
// ----------------------------------------------------------------------------
// tfr_if
// Valid/ready channels of the typed frame receiver: input bytes and results.
// ----------------------------------------------------------------------------
interface tfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface tfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_type;
  logic       checksum_ok;
  logic       set_complete;

  modport source (output valid, output frame_type, output checksum_ok,
                  output set_complete, input ready);
  modport sink   (input valid, input frame_type, input checksum_ok,
                  input set_complete, output ready);
endinterface

// ===== hdl/tfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tfr_cfg_regs
// APB register file holding the frame length of each start byte type.
// ----------------------------------------------------------------------------
module tfr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfr_pkg::ApbAddrW-1:0] paddr,
  input  logic [tfr_pkg::ApbDataW-1:0] pwdata,
  output logic [tfr_pkg::ApbDataW-1:0] prdata,
  output logic                        pready,
  output tfr_pkg::len_table_t         len_o
);
  import tfr_pkg::*;

  len_table_t len_q, len_d;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [LenW-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ApbAddrW-1:2];

  always_comb begin
    len_d  = len_q;
    rd_val = '0;
    unique case (reg_idx)
      REG_LEN_DD, REG_LEN_D2, REG_LEN_D4, REG_LEN_C1, REG_LEN_CC, REG_LEN_CD: begin
        rd_val = len_q[reg_idx];
        if (wr_en) begin
          len_d[reg_idx] = pwdata[LenW-1:0];
        end
      end
      default: rd_val = '0;
    endcase
  end

  assign prdata = {{(ApbDataW-LenW){1'b0}}, rd_val};
  assign len_o  = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= {NumTypes{LEN_RESET}};
    end else begin
      len_q <= len_d;
    end
  end

endmodule

// ===== hdl/tfr_frame_core.sv =====
// ----------------------------------------------------------------------------
// tfr_frame_core
// Input register, frame tracking state and result register of the receiver.
// ----------------------------------------------------------------------------
module tfr_frame_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfr_pkg::len_table_t len_i,
  tfr_in_if.sink              rx,
  tfr_out_if.source           res
);
  import tfr_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;

  // Frame state.
  logic        in_frame_q, in_frame_d;
  logic        active_q, active_d;
  frame_type_t cur_type_q, cur_type_d;
  logic [7:0]  tgt_q, tgt_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  marks_t      marks_q, marks_d;

  // Result register.
  logic        out_vld_q, out_vld_d;
  frame_type_t out_type_q;
  logic        out_ok_q;
  logic        out_done_q;

  logic         adv;
  logic         step;
  logic         emit;
  logic         ok;
  logic         done;
  start_match_t match;
  logic [7:0]   cnt_inc;
  logic [7:0]   ck_val;
  marks_t       marks_or;

  // The pipeline moves whenever the result register is empty or being taken.
  assign adv      = !out_vld_q || res.ready;
  assign rx.ready = !in_vld_q || adv;
  assign step     = in_vld_q && adv;

  assign match    = match_start(in_byte_q);
  assign cnt_inc  = (cnt_q < CNT_MAX) ? cnt_q + 8'd1 : cnt_q;
  assign ck_val   = sum_q + CK_OFFSET;
  assign ok       = (ck_val == in_byte_q);
  assign marks_or = marks_q | type_mark(cur_type_q);

  always_comb begin
    in_frame_d = in_frame_q;
    active_d   = active_q;
    cur_type_d = cur_type_q;
    tgt_d      = tgt_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    marks_d    = marks_q;
    emit       = 1'b0;
    done       = 1'b0;
    if (step) begin
      if (in_op_q == OP_RESTART) begin
        active_d = 1'b1;
      end else if (active_q) begin
        if (!in_frame_q) begin
          if (match.hit) begin
            in_frame_d = 1'b1;
            cur_type_d = match.ftype;
            tgt_d      = len_i[match.ftype];
            cnt_d      = 8'd1;
            sum_d      = in_byte_q;
          end
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc < tgt_q) begin
            sum_d = sum_q + in_byte_q;
          end else begin
            // Last byte of the frame carries the checksum.
            in_frame_d = 1'b0;
            emit       = 1'b1;
            if (ok) begin
              marks_d = marks_or;
              if (marks_or == ALL_MARKS) begin
                done     = 1'b1;
                active_d = 1'b0;
                marks_d  = marks_or & CC_MARK;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = in_vld_q && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      in_frame_q <= 1'b0;
      active_q   <= 1'b1;
      cur_type_q <= TYPE_DD;
      tgt_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      marks_q    <= '0;
    end else begin
      if (rx.ready) begin
        in_vld_q <= rx.valid;
      end
      out_vld_q  <= out_vld_d;
      in_frame_q <= in_frame_d;
      active_q   <= active_d;
      cur_type_q <= cur_type_d;
      tgt_q      <= tgt_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      marks_q    <= marks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) begin
      in_op_q   <= rx.op;
      in_byte_q <= rx.rx_byte;
    end
    if (step && emit) begin
      out_type_q <= cur_type_q;
      out_ok_q   <= ok;
      out_done_q <= done;
    end
  end

  assign res.valid        = out_vld_q;
  assign res.frame_type   = out_type_q;
  assign res.checksum_ok  = out_ok_q;
  assign res.set_complete = out_done_q;

endmodule

// ===== hdl/typed_frame_receiver_with_checksum_unit.sv =====
// ----------------------------------------------------------------------------
// typed_frame_receiver_with_checksum_unit
// Start byte framer with per-type lengths and an additive checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one item per handshake: a received byte (op 0) or a restart
//   command (op 1). While idle the block hunts for one of six start bytes;
//   the APB registers give each type's total frame length. On the last byte
//   of a frame one item leaves on res_o with the frame type, the checksum
//   flag and set_complete. After set_complete, bytes are dropped until a
//   restart item arrives.
//   An item is captured in the input register when it is accepted and is
//   processed when the pipeline next advances, which loads its result into
//   the result register; from there the result is offered on res_o.
//   Throughput: one item per cycle while res_o is not stalled; the running
//   sum and byte count are updated as each item is processed.
//   Reset: all lengths read 2, no frame is open, reception is on and all
//   seen marks are clear.
//   Stalls: while a result waits on res_o, one more item can be held in the
//   input register; further items wait at rx_i until the result is taken.
//   The user must write lengths only while no frame is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module typed_frame_receiver_with_checksum_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tfr_in_if.sink                       rx_i,
  tfr_out_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tfr_pkg::ApbAddrW-1:0] paddr,
  input  logic [tfr_pkg::ApbDataW-1:0] pwdata,
  output logic [tfr_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import tfr_pkg::*;

  len_table_t len_table;

  tfr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len_o   (len_table)
  );

  tfr_frame_core u_frame_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .len_i  (len_table),
    .rx     (rx_i),
    .res    (res_o)
  );

endmodule

// ===== hdl/tfr_chk.sv =====
// ----------------------------------------------------------------------------
// tfr_chk
// Port-level checks of the typed frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module tfr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] frame_type_i,
  input logic       checksum_ok_i,
  input logic       set_complete_i
);
  import tfr_pkg::*;

  // A result waiting on a stalled receiver keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_type_i)
      && $stable(checksum_ok_i) && $stable(set_complete_i))
    else $error("result changed while stalled");

  // The set can only complete on a good frame of a marked type.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && set_complete_i |-> checksum_ok_i && frame_type_i != TYPE_CD)
    else $error("set_complete on a bad or CD frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_type_i <= TYPE_CD)
    else $error("frame type out of range");

  // A fresh result must follow an item accepted on rx_i.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching item");

endmodule

bind typed_frame_receiver_with_checksum_unit tfr_chk u_tfr_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (rx_i.valid),
  .in_ready_i     (rx_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .frame_type_i   (res_o.frame_type),
  .checksum_ok_i  (res_o.checksum_ok),
  .set_complete_i (res_o.set_complete)
);
